// File: rtl/core/pixel_softmax_argmax_top_macros.svh
// Assertion macros shared by the pixel softmax/argmax checker.
// Expects clk_i and rst_ni in scope at the point of use.
`ifndef PIXEL_SOFTMAX_ARGMAX_TOP_MACROS_SVH
`define PIXEL_SOFTMAX_ARGMAX_TOP_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define PSA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define PSA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/psa_pkg.sv
// Package for pixel softmax/argmax: constants, queue entry type, exp tables.
// No dependencies.
package psa_pkg;

  localparam int MAX_CLASSES_DEF = 64;
  localparam int SCORE_W         = 16;
  localparam int CLS_W           = 6;
  localparam int PROB_W          = 16;
  localparam int SUM_W           = 22;
  localparam int QDEPTH          = 2;
  localparam int QAW             = 1;
  localparam logic [PROB_W-1:0] PROB_ONE  = 16'd32768;
  localparam logic [PROB_W-1:0] PROB_HALF = 16'd16384;
  localparam logic [12:0]       M_CLAMP   = 13'd4096;

  typedef struct packed {
    logic                      is_bin;
    logic signed [SCORE_W-1:0] score;   // clamped p in binary mode
    logic                      last;
    logic                      bin_lab; // binary label: 1 selects class 1
  } q_entry_t;

  // round(exp(-k) * 2^24), k = 0..16
  function automatic logic [24:0] exp_int(input logic [4:0] k);
    logic [24:0] v;
    case (k)
      5'd0:  v = 25'd16777216;
      5'd1:  v = 25'd6171993;
      5'd2:  v = 25'd2270549;
      5'd3:  v = 25'd835288;
      5'd4:  v = 25'd307285;
      5'd5:  v = 25'd113044;
      5'd6:  v = 25'd41587;
      5'd7:  v = 25'd15299;
      5'd8:  v = 25'd5628;
      5'd9:  v = 25'd2070;
      5'd10: v = 25'd762;
      5'd11: v = 25'd280;
      5'd12: v = 25'd103;
      5'd13: v = 25'd38;
      5'd14: v = 25'd14;
      5'd15: v = 25'd5;
      default: v = 25'd2;
    endcase
    return v;
  endfunction

  // round(exp(-h/16) * 2^16)
  function automatic logic [16:0] exp_hi(input logic [3:0] h);
    logic [16:0] v;
    case (h)
      4'd0:  v = 17'd65536;
      4'd1:  v = 17'd61565;
      4'd2:  v = 17'd57835;
      4'd3:  v = 17'd54331;
      4'd4:  v = 17'd51039;
      4'd5:  v = 17'd47947;
      4'd6:  v = 17'd45042;
      4'd7:  v = 17'd42313;
      4'd8:  v = 17'd39750;
      4'd9:  v = 17'd37341;
      4'd10: v = 17'd35079;
      4'd11: v = 17'd32954;
      4'd12: v = 17'd30957;
      4'd13: v = 17'd29081;
      4'd14: v = 17'd27319;
      default: v = 17'd25664;
    endcase
    return v;
  endfunction

  // round(exp(-l/256) * 2^16)
  function automatic logic [16:0] exp_lo(input logic [3:0] l);
    logic [16:0] v;
    case (l)
      4'd0:  v = 17'd65536;
      4'd1:  v = 17'd65280;
      4'd2:  v = 17'd65026;
      4'd3:  v = 17'd64772;
      4'd4:  v = 17'd64520;
      4'd5:  v = 17'd64268;
      4'd6:  v = 17'd64018;
      4'd7:  v = 17'd63768;
      4'd8:  v = 17'd63520;
      4'd9:  v = 17'd63272;
      4'd10: v = 17'd63025;
      4'd11: v = 17'd62780;
      4'd12: v = 17'd62535;
      4'd13: v = 17'd62291;
      4'd14: v = 17'd62048;
      default: v = 17'd61806;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/pixel_softmax_argmax_top.sv
// Pixel softmax/argmax. Logits enter one per cycle while the 2-entry queue has room.
// Binary pixel: 2 results. Multi-class pixel of n classes: an exp/sum pass over
// all n logits, then a pass of exp plus 16-step serial divide for each class.
// The back-end sequencer and its restoring divider set the rate; the queue is popped only while idle.
// Reset (rst_ni, async low) clears mode, queue, max/argmax, count and sum; no clear pass.
// Depends on psa_pkg, psa_front, psa_fifo, psa_back.
module pixel_softmax_argmax_top #(
  parameter int MAX_CLASSES = psa_pkg::MAX_CLASSES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration: binary_mode
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic                                cfg_data_i,
  // input transactions: one logit (or binary probability) each
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [psa_pkg::SCORE_W-1:0]  score_i,
  input  logic                                last_class_i,
  // output transactions: one class probability each
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [psa_pkg::CLS_W-1:0]           class_index_o,
  output logic [psa_pkg::PROB_W-1:0]          probability_o,
  output logic [psa_pkg::CLS_W-1:0]           label_o,
  output logic                                last_o
);

  psa_pkg::q_entry_t push_entry, pop_entry;
  logic              push, pop, q_full, q_valid;

  // register writes must happen only while idle; the user is bound, the block does not enforce it, so always ready
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;

  // front: tags each item with the current mode, clamps binary p
  psa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .score_i      (score_i),
    .last_class_i (last_class_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  // decouples input acceptance from the long back-end walk
  psa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (pop_entry)
  );

  // back: buffer, max/argmax, exp table, sum pass, divide pass, output register
  psa_back #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (pop_entry),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .class_index_o (class_index_o),
    .probability_o (probability_o),
    .label_o       (label_o),
    .last_o        (last_o)
  );

endmodule

// File: rtl/core/psa_fifo.sv
// Two-entry transaction queue between front and back of pixel softmax/argmax.
// Depends on psa_pkg.
module psa_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  psa_pkg::q_entry_t  wdata_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output psa_pkg::q_entry_t  rdata_o
);

  psa_pkg::q_entry_t             mem_q [psa_pkg::QDEPTH];
  logic [psa_pkg::QAW-1:0]       wptr_q, rptr_q;
  logic [psa_pkg::QAW:0]         cnt_q;

  assign full_o  = (cnt_q == (psa_pkg::QAW+1)'(psa_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// File: rtl/core/psa_front.sv
// Front end: mode register, input acceptance, item classification.
// Depends on psa_pkg; feeds psa_fifo.
module psa_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_data_i,
  input  logic                                in_valid_i,
  input  logic signed [psa_pkg::SCORE_W-1:0]  score_i,
  input  logic                                last_class_i,
  input  logic                                q_full_i,
  output logic                                push_o,
  output psa_pkg::q_entry_t                   entry_o
);

  logic binary_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      binary_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      binary_mode_q <= cfg_data_i;
    end
  end

  assign push_o = in_valid_i && !q_full_i;

  always_comb begin
    entry_o.is_bin  = binary_mode_q;
    entry_o.last    = last_class_i;
    entry_o.score   = score_i;
    entry_o.bin_lab = 1'b1;
    if (binary_mode_q) begin
      if (score_i[psa_pkg::SCORE_W-1]) entry_o.score = '0;
      entry_o.bin_lab = !(!score_i[psa_pkg::SCORE_W-1] &&
                          (unsigned'(score_i) > psa_pkg::PROB_HALF));
    end
  end

endmodule

// File: rtl/core/psa_back.sv
// Back end: logit buffer, running max/argmax, exp and sum, serial divide, output.
// Depends on psa_pkg; drains psa_fifo.
module psa_back #(
  parameter int MAX_CLASSES = psa_pkg::MAX_CLASSES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  psa_pkg::q_entry_t             q_data_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [psa_pkg::CLS_W-1:0]     class_index_o,
  output logic [psa_pkg::PROB_W-1:0]    probability_o,
  output logic [psa_pkg::CLS_W-1:0]     label_o,
  output logic                          last_o
);

  localparam int IW = $clog2(MAX_CLASSES);
  localparam int CW = $clog2(MAX_CLASSES + 1);
  localparam int SW = psa_pkg::SUM_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_BIN1 = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_E1   = 4'd3;
  localparam logic [3:0] S_E2   = 4'd4;
  localparam logic [3:0] S_E3   = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0] state_q, state_d, ret_q, ret_d;

  logic signed [15:0] mem [MAX_CLASSES];
  logic signed [15:0] rdata_q;

  logic signed [15:0] max_q, max_d;
  logic [IW-1:0]      best_q, best_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic               emit_q, emit_d;
  logic [SW-1:0]      sum_q, sum_d;
  logic [41:0]        p1_q, p1_d;
  logic [37:0]        plo_q, plo_d;
  logic [3:0]         l_q, l_d;
  logic [SW-1:0]      r_q, r_d;
  logic [15:0]        dvd_q, dvd_d;
  logic [3:0]         dcnt_q, dcnt_d;
  logic [15:0]        binp_q, binp_d;
  logic [5:0]         blab_q, blab_d;

  logic [5:0]  rcls_q, rcls_d, rlab_q, rlab_d;
  logic [15:0] rprob_q, rprob_d;
  logic        rlast_q, rlast_d;

  logic        ov_q, ov_d;
  logic [5:0]  ocls_q, olab_q;
  logic [15:0] oprob_q;
  logic        olast_q;

  logic        wr_en, rd_en, out_free;
  logic [16:0] diff;
  logic [12:0] m;
  logic [37:0] hi_prod;
  logic [58:0] full;
  logic [30:0] dvd_init;
  logic [SW:0] r_sh;

  assign out_free = !ov_q || !out_stall_i;
  assign pop_o    = (state_q == S_IDLE) && q_valid_i;
  assign wr_en    = pop_o && !q_data_i.is_bin && (cnt_q < CW'(MAX_CLASSES));
  assign rd_en    = (state_q == S_RD);

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[cnt_q[IW-1:0]] <= q_data_i.score;
    if (rd_en) rdata_q <= mem[idx_q[IW-1:0]];
  end

  always_comb begin
    diff     = {max_q[15], max_q} - {rdata_q[15], rdata_q};
    m        = (diff > 17'(psa_pkg::M_CLAMP)) ? psa_pkg::M_CLAMP : diff[12:0];
    hi_prod  = 38'(p1_q[41:21]) * 38'(psa_pkg::exp_lo(l_q));
    full     = 59'(plo_q) + (59'(hi_prod) << 21) + (59'(1) << 40);
    // e * 2^15 plus half the sum, rounding seed of the divider
    dvd_init = {full[56:41], 15'd0} + 31'(sum_q >> 1);
    r_sh     = {r_q, dvd_q[15]};
  end

  always_comb begin
    state_d = state_q;  ret_d  = ret_q;
    max_d   = max_q;    best_d = best_q;  cnt_d = cnt_q;  idx_d = idx_q;
    emit_d  = emit_q;   sum_d  = sum_q;   p1_d  = p1_q;   plo_d = plo_q;
    l_d     = l_q;      r_d   = r_q;      dvd_d = dvd_q;
    dcnt_d  = dcnt_q;   binp_d = binp_q;  blab_d = blab_q;
    rcls_d  = rcls_q;   rprob_d = rprob_q; rlab_d = rlab_q; rlast_d = rlast_q;
    ov_d    = ov_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          if (q_data_i.is_bin) begin
            binp_d  = q_data_i.score;
            blab_d  = {5'd0, q_data_i.bin_lab};
            rcls_d  = 6'd0;
            rprob_d = q_data_i.score;
            rlab_d  = {5'd0, q_data_i.bin_lab};
            rlast_d = 1'b0;
            ret_d   = S_BIN1;
            state_d = S_OUT;
          end else begin
            if (cnt_q < CW'(MAX_CLASSES)) begin
              if (q_data_i.score > max_q) begin
                max_d  = q_data_i.score;
                best_d = cnt_q[IW-1:0];
              end
              cnt_d = cnt_q + 1'b1;
            end
            if (q_data_i.last) begin
              idx_d   = '0;
              sum_d   = '0;
              emit_d  = 1'b0;
              state_d = S_RD;
            end
          end
        end
      end
      S_BIN1: begin
        rcls_d  = 6'd1;
        rprob_d = psa_pkg::PROB_ONE - binp_q;
        rlab_d  = blab_q;
        rlast_d = 1'b1;
        ret_d   = S_IDLE;
        state_d = S_OUT;
      end
      S_RD: state_d = S_E1;
      S_E1: begin
        p1_d    = 42'(psa_pkg::exp_int({1'b0, m[11:8]} | {m[12], 4'd0}))
                  * 42'(psa_pkg::exp_hi(m[7:4]));
        l_d     = m[3:0];
        state_d = S_E2;
      end
      S_E2: begin
        plo_d   = 38'(p1_q[20:0]) * 38'(psa_pkg::exp_lo(l_q));
        state_d = S_E3;
      end
      S_E3: begin
        if (!emit_q) begin
          sum_d = sum_q + SW'(full[56:41]);
          if (idx_q + 1'b1 == cnt_q) begin
            idx_d  = '0;
            emit_d = 1'b1;
          end else begin
            idx_d = idx_q + 1'b1;
          end
          state_d = S_RD;
        end else begin
          state_d = S_DIV;
          dcnt_d  = 4'd15;
          r_d     = SW'(dvd_init[30:16]);
          dvd_d   = dvd_init[15:0];
        end
      end
      S_DIV: begin
        if (r_sh >= {1'b0, sum_q}) begin
          r_d   = SW'(r_sh - {1'b0, sum_q});
          dvd_d = {dvd_q[14:0], 1'b1};
        end else begin
          r_d   = r_sh[SW-1:0];
          dvd_d = {dvd_q[14:0], 1'b0};
        end
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == '0) state_d = S_FIN;
      end
      S_FIN: begin
        rcls_d  = 6'(idx_q);
        rprob_d = (dvd_q > psa_pkg::PROB_ONE) ? psa_pkg::PROB_ONE : dvd_q;
        rlab_d  = 6'(best_q);
        rlast_d = (idx_q + 1'b1 == cnt_q);
        if (idx_q + 1'b1 == cnt_q) begin
          max_d  = 16'sh8000;
          best_d = '0;
          cnt_d  = '0;
          sum_d  = '0;
          ret_d  = S_IDLE;
        end else begin
          ret_d = S_RD;
        end
        idx_d   = idx_q + 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          state_d = ret_q;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      max_q   <= 16'sh8000;
      best_q  <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
      emit_q  <= 1'b0;
      sum_q   <= '0;
      dcnt_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      max_q   <= max_d;
      best_q  <= best_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      emit_q  <= emit_d;
      sum_q   <= sum_d;
      dcnt_q  <= dcnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q    <= p1_d;
    plo_q   <= plo_d;
    l_q     <= l_d;
    r_q     <= r_d;
    dvd_q   <= dvd_d;
    binp_q  <= binp_d;
    blab_q  <= blab_d;
    rcls_q  <= rcls_d;
    rprob_q <= rprob_d;
    rlab_q  <= rlab_d;
    rlast_q <= rlast_d;
    if (state_q == S_OUT && out_free) begin
      ocls_q  <= rcls_q;
      oprob_q <= rprob_q;
      olab_q  <= rlab_q;
      olast_q <= rlast_q;
    end
  end

  assign out_valid_o   = ov_q;
  assign class_index_o = ocls_q;
  assign probability_o = oprob_q;
  assign label_o       = olab_q;
  assign last_o        = olast_q;

endmodule

// File: rtl/core/psa_checker.sv
// Port-level checks for pixel_softmax_argmax_top, bound to the top level.
// Depends on pixel_softmax_argmax_top_macros.svh.
`include "pixel_softmax_argmax_top_macros.svh"

module psa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [5:0]  class_index_o,
  input logic [15:0] probability_o,
  input logic [5:0]  label_o,
  input logic        last_o
);

  logic [28:0] out_word;
  assign out_word = {class_index_o, probability_o, label_o, last_o};

  `PSA_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `PSA_ASSERT_NXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_word))
  `PSA_ASSERT(a_prob_range, !out_valid_o || probability_o <= 16'd32768)
  `PSA_ASSERT(a_first_idx, !(out_valid_o && last_o && class_index_o == 6'd0) || probability_o == 16'd32768 || label_o <= 6'd1)

endmodule

bind pixel_softmax_argmax_top psa_checker u_psa_checker (.*);

// File: sim/tb_pixel_softmax_argmax_top.sv
// Testbench for pixel_softmax_argmax_top: drives logits and binary probabilities,
// predicts per-class softmax/argmax results and checks them. Depends on psa_pkg.
module tb_pixel_softmax_argmax_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int RANDOM_ITEMS   = 60;

  typedef struct {
    logic [psa_pkg::CLS_W-1:0]  cls;
    logic [psa_pkg::PROB_W-1:0] prob;
    logic [psa_pkg::CLS_W-1:0]  lab;
    logic                       last;
  } prob_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_data_i = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [psa_pkg::SCORE_W-1:0] score_i = '0;
  logic last_class_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [psa_pkg::CLS_W-1:0] class_index_o;
  logic [psa_pkg::PROB_W-1:0] probability_o;
  logic [psa_pkg::CLS_W-1:0] label_o;
  logic last_o;

  // Predictor state, mirrors the block
  logic                               mode_bin;
  logic signed [psa_pkg::SCORE_W-1:0] logits[psa_pkg::MAX_CLASSES_DEF];
  logic signed [psa_pkg::SCORE_W-1:0] peak_logit;
  int unsigned                        peak_class;
  int unsigned                        n_logits;
  prob_result_t                       pending_probs[$];

  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;     // no idling in the final part
  bit  hold_rx = 1'b0;   // long receiver hold-off request
  int  hold_len = 0;

  pixel_softmax_argmax_top i_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Fixed-point exp of (x - mx) in Q1.15 via three lookup tables
  function automatic int unsigned exp_of_gap(logic signed [psa_pkg::SCORE_W-1:0] x,
                                             logic signed [psa_pkg::SCORE_W-1:0] mx);
    int m;
    int unsigned k, h, l;
    logic [127:0] p;
    m = int'(mx) - int'(x);
    if (m < 0) m = 0;
    if (m > 4096) m = 4096;
    k = m >> 8;
    if (k > 16) k = 16;
    h = (m >> 4) & 15;
    l = m & 15;
    case (k)
      0: p = 16777216; 1: p = 6171993; 2: p = 2270549; 3: p = 835288;
      4: p = 307285; 5: p = 113044; 6: p = 41587; 7: p = 15299;
      8: p = 5628; 9: p = 2070; 10: p = 762; 11: p = 280;
      12: p = 103; 13: p = 38; 14: p = 14; 15: p = 5; default: p = 2;
    endcase
    case (h)
      0: p = p * 65536; 1: p = p * 61565; 2: p = p * 57835; 3: p = p * 54331;
      4: p = p * 51039; 5: p = p * 47947; 6: p = p * 45042; 7: p = p * 42313;
      8: p = p * 39750; 9: p = p * 37341; 10: p = p * 35079; 11: p = p * 32954;
      12: p = p * 30957; 13: p = p * 29081; 14: p = p * 27319; default: p = p * 25664;
    endcase
    case (l)
      0: p = p * 65536; 1: p = p * 65280; 2: p = p * 65026; 3: p = p * 64772;
      4: p = p * 64520; 5: p = p * 64268; 6: p = p * 64018; 7: p = p * 63768;
      8: p = p * 63520; 9: p = p * 63272; 10: p = p * 63025; 11: p = p * 62780;
      12: p = p * 62535; 13: p = p * 62291; 14: p = p * 62048; default: p = p * 61806;
    endcase
    return int'((p + (128'd1 << 40)) >> 41);
  endfunction

  function automatic void clear_pixel_state();
    peak_logit = 16'sh8000;
    peak_class = 0;
    n_logits = 0;
  endfunction

  // Append one expected result at the tail of the queue
  function automatic void queue_result(prob_result_t r);
    pending_probs.insert(pending_probs.size(), r);
  endfunction

  // Expected results for one accepted transaction
  function automatic void predict_softmax(logic signed [psa_pkg::SCORE_W-1:0] x, logic lastc);
    prob_result_t r;
    int unsigned p, lab, total, e;
    logic [63:0] q;
    if (mode_bin) begin
      p = (x < 0) ? 0 : int'(x);
      lab = (p > 16384) ? 0 : 1;
      r.cls = 6'd0; r.prob = 16'(p); r.lab = 6'(lab); r.last = 1'b0;
      queue_result(r);
      r.cls = 6'd1; r.prob = 16'(32768 - p); r.last = 1'b1;
      queue_result(r);
      return;
    end
    if (n_logits < psa_pkg::MAX_CLASSES_DEF) begin
      logits[n_logits] = x;
      if (x > peak_logit) begin
        peak_logit = x;
        peak_class = n_logits;
      end
      n_logits++;
    end
    if (!lastc) return;
    total = 0;
    for (int i = 0; i < n_logits; i++) total += exp_of_gap(logits[i], peak_logit);
    total &= 32'h3FFFFF;
    for (int i = 0; i < n_logits; i++) begin
      e = exp_of_gap(logits[i], peak_logit);
      q = 0;
      if (total != 0) q = (64'(e) * 32768 + 64'(total >> 1)) / 64'(total);
      if (q > 32768) q = 32768;
      r.cls = 6'(i); r.prob = q[15:0]; r.lab = 6'(peak_class);
      r.last = (i + 1 == n_logits);
      queue_result(r);
    end
    clear_pixel_state();
  endfunction

  // Send one transaction; random idle bursts before it unless quiet
  task automatic send_score(logic signed [psa_pkg::SCORE_W-1:0] x, logic lastc);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    score_i <= x;
    last_class_i <= lastc;
    do @(posedge clk_i); while (in_stall_o);
    predict_softmax(x, lastc);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_probs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(logic m);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mode_bin = m;
  endtask

  // One pixel of n logits with random content in a narrow or full range
  task automatic send_pixel(int n, bit wide);
    logic signed [psa_pkg::SCORE_W-1:0] x;
    for (int i = 0; i < n; i++) begin
      x = wide ? 16'($urandom) : $signed(16'($urandom_range(0, 3000)) - 16'sd1500);
      send_score(x, i == n - 1);
    end
  endtask

  task automatic test_multiclass_directed();
    send_score(16'sh7FFF, 1'b0);     // extremes, max first
    send_score(16'sh8000, 1'b0);
    send_score(16'sh7FFF, 1'b1);     // tie keeps earlier class
    send_score(16'sh1234, 1'b1);     // single-class pixel
    send_score(16'sh0000, 1'b0);     // clamp below -16
    send_score(-16'sd4097, 1'b0);
    send_score(-16'sd4096, 1'b1);
    send_score(16'sh8000, 1'b0);     // all at most negative
    send_score(16'sh8000, 1'b1);
    send_score(16'sh5555, 1'b0);
    send_score(-16'sh5556, 1'b1);
    wait_drained();
  endtask

  task automatic test_too_many_classes();
    send_pixel(psa_pkg::MAX_CLASSES_DEF + 3, 1'b0);
    wait_drained();
  endtask

  task automatic test_binary_directed();
    write_mode(1'b1);
    send_score(16'sd16384, 1'b1);    // boundary: class 1
    send_score(16'sd16385, 1'b0);
    send_score(16'sd32767, 1'b0);
    send_score(16'sh8000, 1'b1);     // negative taken as zero
    send_score(16'sd0, 1'b0);
    wait_drained();
  endtask

  task automatic test_mode_switch_mid_pixel();
    write_mode(1'b0);
    send_score(16'sd100, 1'b0);
    send_score(16'sd300, 1'b0);
    wait_drained();
    write_mode(1'b1);
    send_score(16'sd20000, 1'b1);
    wait_drained();
    write_mode(1'b0);
    send_score(16'sd200, 1'b1);      // resumes earlier pixel
    wait_drained();
  endtask

  // Receiver holds off while sender keeps offering
  task automatic test_backpressure();
    hold_len = 300;
    hold_rx = 1'b1;
    send_pixel(4, 1'b0);
    send_pixel(3, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int sent;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent > 40) quiet = 1'b1;
      if ($urandom_range(0, 4) == 0) begin
        wait_drained();
        write_mode(1'($urandom_range(0, 1)));
      end
      if (mode_bin) begin
        send_score(16'($urandom), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 6);
        if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
        send_pixel(n, 1'($urandom_range(0, 1)));
        sent += n;
      end
    end
    wait_drained();
  endtask

  // Receiver stall: random bursts, long hold-off on request
  always @(posedge clk_i) begin
    if (hold_rx) begin
      if (hold_len == 0) begin
        hold_rx <= 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b1;
        hold_len <= hold_len - 1;
      end
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
    end else if (quiet || !out_stall_i || $urandom_range(0, 2) == 0) begin
      out_stall_i <= 1'b0;
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    prob_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_probs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: class %0d prob %0d", class_index_o, probability_o);
      end else begin
        want = pending_probs.pop_front();
        if (class_index_o !== want.cls || probability_o !== want.prob ||
            label_o !== want.lab || last_o !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp cls %0d prob %0d lab %0d last %0d, got %0d %0d %0d %0d",
                     want.cls, want.prob, want.lab, want.last,
                     class_index_o, probability_o, label_o, last_o);
        end
      end
    end
  end

  // Watchdog on cycles with no accepted transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    mode_bin = 1'b0;
    clear_pixel_state();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_multiclass_directed();
    test_too_many_classes();
    test_binary_directed();
    test_mode_switch_mid_pixel();
    test_backpressure();
    test_random_traffic();
    write_mode(1'b0);
    wait_drained();
    if (mismatches == 0 && pending_probs.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
